### rtl/sfbi_pkg.sv
`timescale 1ns / 1ps

package sfbi_pkg;

  localparam int BUCKET_BITS = 20;
  localparam int SUM_BITS    = 32;
  localparam int BYTE_BITS   = 8;
  localparam int FILL_BITS   = $clog2(SUM_BITS / BYTE_BITS);
  localparam int STEP_BITS   = $clog2(SUM_BITS);
  localparam int OUT_TDATA_W = ((BUCKET_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] sum;
  } sfbi_push_t;

  typedef enum logic [1:0] {
    SFBI_IDLE,
    SFBI_RUN,
    SFBI_DONE
  } sfbi_state_e;

endpackage

### rtl/sfbi_front.sv
`timescale 1ns / 1ps

module sfbi_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           key_valid_i,
  output logic                           key_ready_o,
  input  logic [sfbi_pkg::BYTE_BITS-1:0] key_byte_i,
  input  logic                           key_last_i,
  input  logic                           full_i,
  output sfbi_pkg::sfbi_push_t           push_o
);

  logic [sfbi_pkg::SUM_BITS-1:0]  group_word_q, group_word_d;
  logic [sfbi_pkg::FILL_BITS-1:0] group_fill_q, group_fill_d;
  logic [sfbi_pkg::SUM_BITS-1:0]  running_sum_q, running_sum_d;
  logic [sfbi_pkg::SUM_BITS-1:0]  word_next;
  logic [sfbi_pkg::SUM_BITS-1:0]  sum_next;
  logic                           fire;
  logic                           group_full;

  assign key_ready_o = !full_i;
  assign fire        = key_valid_i && key_ready_o;
  assign word_next   = {group_word_q[sfbi_pkg::SUM_BITS-sfbi_pkg::BYTE_BITS-1:0], key_byte_i};
  assign group_full  = (group_fill_q == '1);
  // full or partial group, the final sum is always the old sum plus the new word
  assign sum_next    = running_sum_q + word_next;

  always_comb begin
    group_word_d  = group_word_q;
    group_fill_d  = group_fill_q;
    running_sum_d = running_sum_q;
    if (fire) begin
      if (key_last_i || group_full) begin
        group_word_d  = '0;
        group_fill_d  = '0;
        running_sum_d = key_last_i ? '0 : sum_next;
      end else begin
        group_word_d = word_next;
        group_fill_d = group_fill_q + 1'b1;
      end
    end
  end

  assign push_o.valid = fire && key_last_i;
  assign push_o.sum   = sum_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_word_q  <= '0;
      group_fill_q  <= '0;
      running_sum_q <= '0;
    end else begin
      group_word_q  <= group_word_d;
      group_fill_q  <= group_fill_d;
      running_sum_q <= running_sum_d;
    end
  end

endmodule

### rtl/sfbi_fifo.sv
`timescale 1ns / 1ps

module sfbi_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfbi_pkg::sfbi_push_t          push_i,
  output logic                          full_o,
  output logic                          pop_valid_o,
  input  logic                          pop_ready_i,
  output logic [sfbi_pkg::SUM_BITS-1:0] pop_sum_o
);

  logic [sfbi_pkg::SUM_BITS-1:0] mem_q [sfbi_pkg::FIFO_DEPTH];
  logic [sfbi_pkg::FIFO_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [sfbi_pkg::FIFO_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [sfbi_pkg::FIFO_CW-1:0]  count_q, count_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o      = (count_q == sfbi_pkg::FIFO_CW'(sfbi_pkg::FIFO_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_sum_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/sfbi_mod.sv
`timescale 1ns / 1ps

module sfbi_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [sfbi_pkg::BUCKET_BITS-1:0] bucket_count_i,
  input  logic                             sum_valid_i,
  output logic                             sum_ready_o,
  input  logic [sfbi_pkg::SUM_BITS-1:0]    sum_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sfbi_pkg::BUCKET_BITS-1:0] out_index_o
);

  sfbi_pkg::sfbi_state_e                state_q, state_d;
  logic [sfbi_pkg::SUM_BITS-1:0]        dividend_q, dividend_d;
  logic [sfbi_pkg::BUCKET_BITS-1:0]     rem_q, rem_d;
  logic [sfbi_pkg::STEP_BITS-1:0]       step_q, step_d;
  logic [sfbi_pkg::BUCKET_BITS:0]       rem_shift;
  logic [sfbi_pkg::BUCKET_BITS:0]       divisor_ext;

  // restoring remainder, one dividend bit per cycle
  assign rem_shift   = {rem_q, dividend_q[sfbi_pkg::SUM_BITS-1]};
  assign divisor_ext = {1'b0, bucket_count_i};

  assign sum_ready_o = (state_q == sfbi_pkg::SFBI_IDLE);
  assign out_valid_o = (state_q == sfbi_pkg::SFBI_DONE);
  assign out_index_o = (bucket_count_i == '0) ? '0 : rem_q;

  always_comb begin
    state_d    = state_q;
    dividend_d = dividend_q;
    rem_d      = rem_q;
    step_d     = step_q;
    case (state_q)
      sfbi_pkg::SFBI_IDLE: begin
        if (sum_valid_i) begin
          dividend_d = sum_i;
          rem_d      = '0;
          step_d     = '0;
          state_d    = sfbi_pkg::SFBI_RUN;
        end
      end
      sfbi_pkg::SFBI_RUN: begin
        dividend_d = {dividend_q[sfbi_pkg::SUM_BITS-2:0], 1'b0};
        if (rem_shift >= divisor_ext) begin
          rem_d = sfbi_pkg::BUCKET_BITS'(rem_shift - divisor_ext);
        end else begin
          rem_d = sfbi_pkg::BUCKET_BITS'(rem_shift);
        end
        step_d = step_q + 1'b1;
        if (step_q == sfbi_pkg::STEP_BITS'(sfbi_pkg::SUM_BITS - 1)) begin
          state_d = sfbi_pkg::SFBI_DONE;
        end
      end
      sfbi_pkg::SFBI_DONE: begin
        if (out_ready_i) begin
          state_d = sfbi_pkg::SFBI_IDLE;
        end
      end
      default: state_d = sfbi_pkg::SFBI_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfbi_pkg::SFBI_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    rem_q      <= rem_d;
  end

endmodule

### rtl/string_fold_bucket_index.sv
`timescale 1ns / 1ps

// String fold to bucket index.
// Slave stream carries a key one byte per transfer: tdata holds key_byte,
// tlast marks the key's final byte. Bytes are packed big-endian into 32-bit
// groups that are summed with wraparound; the master stream returns one
// transfer per key with bucket_index = sum mod bucket_count (0 if the count
// is 0) in tdata bits [19:0], upper bits zero.
// bucket_count must be written through cfg_we_i / cfg_wdata_i only while no
// key is in flight; the block does not enforce this. Key bytes are taken one
// per cycle while the queue is not full; the final sum enters a two-entry
// queue, and a bit-serial remainder unit loads it, reduces it a dividend bit
// at a time and holds the result until the receiver takes it. Short keys fill
// the queue and then the slave side stalls until the back end frees an entry.
// When the receiver stalls, the result stays on the master port and the
// front keeps taking bytes until the queue is full.
// Reset clears the key state, the queue and bucket_count, and returns the remainder unit to idle.
module string_fold_bucket_index (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfbi_pkg::BUCKET_BITS-1:0] cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfbi_pkg::BYTE_BITS-1:0]   s_axis_tdata,  // [7:0] key_byte
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sfbi_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [19:0] bucket_index
);

  logic [sfbi_pkg::BUCKET_BITS-1:0] bucket_count_q;
  sfbi_pkg::sfbi_push_t             push;
  logic                             fifo_full;
  logic                             fifo_valid;
  logic                             fifo_ready;
  logic [sfbi_pkg::SUM_BITS-1:0]    fifo_sum;
  logic [sfbi_pkg::BUCKET_BITS-1:0] out_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= '0;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  sfbi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (s_axis_tvalid),
    .key_ready_o (s_axis_tready),
    .key_byte_i  (s_axis_tdata),
    .key_last_i  (s_axis_tlast),
    .full_i      (fifo_full),
    .push_o      (push)
  );

  sfbi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (fifo_full),
    .pop_valid_o (fifo_valid),
    .pop_ready_i (fifo_ready),
    .pop_sum_o   (fifo_sum)
  );

  sfbi_mod u_mod (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .sum_valid_i    (fifo_valid),
    .sum_ready_o    (fifo_ready),
    .sum_i          (fifo_sum),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_index_o    (out_index)
  );

  assign m_axis_tdata = sfbi_pkg::OUT_TDATA_W'(out_index);

`ifndef NO_ASSERTIONS
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bucket_count_q != '0) |-> (out_index < bucket_count_q))
    else $error("bucket index not below bucket count");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && bucket_count_q == '0) |-> (out_index == '0))
    else $error("nonzero index with zero bucket count");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !fifo_full)
    else $error("final sum pushed into a full queue");

  a_result_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!fifo_ready, 1))
    else $error("result raised without a remainder run");
`endif

endmodule
